// File: hw/rtl/mtcm_pkg.sv
// Shared constants, tables and helper functions for the cube mesher.
package mtcm_pkg;

   // Default grid geometry
   localparam int GRID_BITS_DEF = 10;
   localparam int FRAC_BITS_DEF = 16;

   // Sample and magnitude widths
   localparam int CORNER_W  = 32;
   localparam int VALUE_W   = CORNER_W + 1;
   localparam int MAG_W     = VALUE_W;
   localparam int NUM_TETS  = 6;
   localparam int NUM_EDGES = 6;
   localparam int QUEUE_DEPTH = 2;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_ISO_LEVEL = 1'b0;
   localparam logic REG_NUDGE     = 1'b1;

   // Six tetrahedra around the 0-7 diagonal
   localparam logic [2:0] TET_TAB [0:5][0:3] = '{
      '{3'd0, 3'd1, 3'd3, 3'd7}, '{3'd0, 3'd1, 3'd5, 3'd7}, '{3'd0, 3'd4, 3'd5, 3'd7},
      '{3'd0, 3'd4, 3'd6, 3'd7}, '{3'd0, 3'd2, 3'd6, 3'd7}, '{3'd0, 3'd2, 3'd3, 3'd7}
   };

   // Local edge endpoints of a tetrahedron
   localparam logic [1:0] EDGE_A [0:5] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] EDGE_B [0:5] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

   // Edge joining two local corners
   localparam logic [2:0] PAIR_EDGE [0:3][0:3] = '{
      '{3'd0, 3'd0, 3'd1, 3'd2}, '{3'd0, 3'd0, 3'd3, 3'd4},
      '{3'd1, 3'd3, 3'd0, 3'd5}, '{3'd2, 3'd4, 3'd5, 3'd0}
   };

   // Triangle plan of one mixed tetrahedron
   typedef struct packed {
      logic            quad;
      logic [2:0]      nin;
      logic [3:0][2:0] src;
   } plan_type;

   // Width of one queued cube: values, inside bits, mixed bits, origins
   function automatic int entry_width(input int grid_bits);
      return 8 * VALUE_W + 8 + NUM_TETS + 3 * grid_bits;
   endfunction

   // Cut-point order for a tetrahedron inside mask
   function automatic plan_type tet_plan(input logic [3:0] tmask);
      plan_type   p;
      logic [1:0] ins0, ins1, outs0, outs1;
      logic [2:0] ni, no;
      logic [1:0] nq;
      p     = '0;
      ins0  = '0;
      ins1  = '0;
      outs0 = '0;
      outs1 = '0;
      ni    = '0;
      no    = '0;
      nq    = '0;
      for (int c = 0; c < 4; c++) begin
         if (tmask[c]) begin
            if (ni == 3'd0) ins0 = 2'(c);
            else ins1 = 2'(c);
            ni = ni + 3'd1;
         end else begin
            if (no == 3'd0) outs0 = 2'(c);
            else outs1 = 2'(c);
            no = no + 3'd1;
         end
      end
      p.nin  = ni;
      p.quad = (ni == 3'd2);
      if (p.quad) begin
         p.src[0] = PAIR_EDGE[ins0][outs0];
         p.src[1] = PAIR_EDGE[ins0][outs1];
         p.src[2] = PAIR_EDGE[ins1][outs1];
         p.src[3] = PAIR_EDGE[ins1][outs0];
      end else begin
         for (int e = 0; e < NUM_EDGES; e++) begin
            if ((tmask[EDGE_A[e]] != tmask[EDGE_B[e]]) && (nq < 2'd3)) begin
               p.src[nq] = 3'(e);
               nq = nq + 2'd1;
            end
         end
      end
      return p;
   endfunction

endpackage

// File: hw/rtl/marching_tetrahedra_cube_mesher_unit.sv
// Top level of the marching-tetrahedra cube mesher.
//
// req channel: one transaction per grid cube (eight signed Q16.16 corners,
// origin i/j/k, missing flag on tuser). rsp channel: one transaction per
// triangle, three vertices of unsigned grid.fraction coordinates, tlast on
// the final triangle of a cube. A cube that is missing or has no surface
// gives no transaction at all.
// The front end takes a cube every cycle while its two-entry queue has room;
// empty cubes are dropped as they are taken. The back end works one surface
// cube at a time: it fetches the cube, visits each tetrahedron, checks each
// edge, divides on each cut edge with a bit-serial divider, and for each
// triangle loads the vertices and runs nine steps of one shared multiplier
// for the winding test.
// A stalled rsp channel holds the triangle in the output register; the back
// end stops, the queue fills, then req_tready drops.
// Reset (synchronous, active high) empties queue and back end and loads
// iso_level = 0, nudge = 66. Write registers only while the block is idle.
module marching_tetrahedra_cube_mesher_unit #(
   parameter int GRID_BITS = mtcm_pkg::GRID_BITS_DEF,
   parameter int FRAC_BITS = mtcm_pkg::FRAC_BITS_DEF,
   parameter int IN_TW  = ((8 * mtcm_pkg::CORNER_W + 3 * GRID_BITS + 7) / 8) * 8,
   parameter int OUT_TW = ((9 * (GRID_BITS + FRAC_BITS) + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // corner_0..corner_7, origin_i, origin_j, origin_k
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [IN_TW-1:0]                  req_tdata,
   // missing
   input  logic                              req_tuser,
   // a_i, a_j, a_k, b_i, b_j, b_k, c_i, c_j, c_k
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [OUT_TW-1:0]                 rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mtcm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [mtcm_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [mtcm_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import mtcm_pkg::*;

   localparam int ENTRY_W = entry_width(GRID_BITS);

   logic signed [CORNER_W-1:0] iso_ff, iso_in;
   logic [CORNER_W-2:0]        nudge_ff, nudge_in;
   logic                       reg_sel, wr_en;
   logic                       q_full, q_push, q_pop, q_valid;
   logic [ENTRY_W-1:0]         q_in_data, q_head;

   // Register file
   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      iso_in   = iso_ff;
      nudge_in = nudge_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_ISO_LEVEL: iso_in   = pwdata;
            REG_NUDGE:     nudge_in = pwdata[CORNER_W-2:0];
            default:       iso_in   = iso_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_ISO_LEVEL: prdata = iso_ff;
         REG_NUDGE:     prdata = {1'b0, nudge_ff};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iso_ff   <= '0;
         nudge_ff <= (CORNER_W-1)'(66);
      end else begin
         iso_ff   <= iso_in;
         nudge_ff <= nudge_in;
      end
   end

   mtcm_front #(.GRID_BITS(GRID_BITS), .IN_TW(IN_TW)) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .iso       (iso_ff),
      .nudge     (nudge_ff),
      .q_full    (q_full),
      .push      (q_push),
      .push_data (q_in_data)
   );

   mtcm_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .head_valid(q_valid),
      .head_data (q_head)
   );

   mtcm_back #(.GRID_BITS(GRID_BITS), .FRAC_BITS(FRAC_BITS), .OUT_TW(OUT_TW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .iso       (iso_ff),
      .head_valid(q_valid),
      .head_data (q_head),
      .pop       (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

// File: hw/rtl/mtcm_front.sv
// Front end: nudges corners, classifies tetrahedra and drops missing and empty cubes.
module mtcm_front #(
   parameter int GRID_BITS = mtcm_pkg::GRID_BITS_DEF,
   parameter int IN_TW     = 288
) (
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [IN_TW-1:0]                        req_tdata,
   input  logic                                    req_tuser,
   input  logic signed [mtcm_pkg::CORNER_W-1:0]    iso,
   input  logic [mtcm_pkg::CORNER_W-2:0]           nudge,
   input  logic                                    q_full,
   output logic                                    push,
   output logic [mtcm_pkg::entry_width(GRID_BITS)-1:0] push_data
);
   import mtcm_pkg::*;

   logic signed [CORNER_W-1:0] corner [8];
   logic signed [VALUE_W-1:0]  cv [8];
   logic signed [VALUE_W-1:0]  nudged;
   logic [7:0]                 above;
   logic [NUM_TETS-1:0]        mixed;
   logic [3:0]                 tm [NUM_TETS];

   assign nudged = $signed({iso[CORNER_W-1], iso}) + $signed({2'b00, nudge});

   // Nudge corners on the level, mark inside corners
   always_comb begin
      for (int c = 0; c < 8; c++) begin
         corner[c] = req_tdata[c*CORNER_W +: CORNER_W];
         above[c]  = (corner[c] >= iso);
         cv[c]     = (corner[c] == iso) ? nudged : VALUE_W'(corner[c]);
      end
   end

   // Tetrahedra with both inside and outside corners
   always_comb begin
      for (int t = 0; t < NUM_TETS; t++) begin
         for (int c = 0; c < 4; c++) tm[t][c] = above[TET_TAB[t][c]];
         mixed[t] = (tm[t] != 4'h0) && (tm[t] != 4'hF);
      end
   end

   assign req_tready = !q_full;
   assign push = req_tvalid && !q_full && !req_tuser && (mixed != '0);
   assign push_data = {req_tdata[8*CORNER_W +: 3*GRID_BITS], mixed, above,
                       cv[7], cv[6], cv[5], cv[4], cv[3], cv[2], cv[1], cv[0]};

endmodule

// File: hw/rtl/mtcm_queue.sv
// Short queue of classified cubes between front and back end.
module mtcm_queue #(
   parameter int WIDTH = 300,
   parameter int DEPTH = mtcm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = entry_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) entry_ff[wr_ff] <= push_data;
   end

endmodule

// File: hw/rtl/mtcm_back.sv
// Back end: cut-point division, winding test and triangle output register.
module mtcm_back #(
   parameter int GRID_BITS = mtcm_pkg::GRID_BITS_DEF,
   parameter int FRAC_BITS = mtcm_pkg::FRAC_BITS_DEF,
   parameter int OUT_TW    = 240
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic signed [mtcm_pkg::CORNER_W-1:0]        iso,
   input  logic                                        head_valid,
   input  logic [mtcm_pkg::entry_width(GRID_BITS)-1:0] head_data,
   output logic                                        pop,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   output logic [OUT_TW-1:0]                           rsp_tdata,
   output logic                                        rsp_tlast
);
   import mtcm_pkg::*;

   localparam int ENTRY_W = entry_width(GRID_BITS);
   localparam int INS_LSB = 8 * VALUE_W;
   localparam int MIX_LSB = INS_LSB + 8;
   localparam int ORG_LSB = MIX_LSB + NUM_TETS;
   localparam int PW   = FRAC_BITS + 1;
   localparam int EW   = FRAC_BITS + 2;
   localparam int NRW  = 2 * FRAC_BITS + 5;
   localparam int CSW  = FRAC_BITS + 5;
   localparam int PRW  = NRW + CSW;
   localparam int ACCW = PRW + 2;
   localparam int CW   = GRID_BITS + FRAC_BITS;
   localparam int DCW  = $clog2(FRAC_BITS + 1);
   localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_TET, S_EDGE_A, S_EDGE_B, S_DIV, S_VERT, S_PREP, S_MUL, S_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [ENTRY_W-1:0]      cube_ff, cube_in;
   logic [2:0]              ti_ff, ti_in, e_ff, e_in;
   logic                    tr_ff, tr_in;
   logic signed [VALUE_W-1:0] va_ff, va_in;
   logic [MAG_W:0]          rem_ff, rem_in;
   logic [MAG_W-1:0]        den_ff, den_in;
   logic [PW-1:0]           q_ff, q_in;
   logic [DCW-1:0]          dcnt_ff, dcnt_in;
   logic [PW-1:0]           t_ff [NUM_EDGES], t_in [NUM_EDGES];
   logic [1:0]              vcnt_ff, vcnt_in;
   logic [PW-1:0]           v_ff [3][3], v_in [3][3];
   logic signed [EW-1:0]    e1_ff [3], e1_in [3], e2_ff [3], e2_in [3];
   logic signed [CSW-1:0]   cs_ff [3], cs_in [3];
   logic signed [NRW-1:0]   nr_ff [3], nr_in [3];
   logic signed [ACCW-1:0]  acc_ff, acc_in;
   logic signed [PRW-1:0]   prod_ff, prod_in;
   logic [3:0]              mstep_ff, mstep_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_TW-1:0]       rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [7:0]              above;
   logic [NUM_TETS-1:0]     mixed;
   logic [GRID_BITS-1:0]    org [3];
   logic [3:0]              tmask;
   plan_type                plan;
   logic [2:0]              cv_idx;
   logic signed [VALUE_W-1:0] cv_sel;
   logic [2:0]              ca_e, cb_e;
   logic signed [VALUE_W:0] ndiff, ddiff;
   logic [MAG_W:0]          r2;
   logic                    ge;
   logic [2:0]              sidx, ca_s, cb_s;
   logic [PW+1:0]           s3;
   logic [PW+2:0]           pn, sub3;
   logic [1:0]              sumd;
   logic [3:0]              s3cnt;
   logic signed [NRW-1:0]   ma;
   logic signed [CSW-1:0]   mb;
   logic                    later, more, neg, slot_free;
   logic [CW-1:0]           vo [3][3];

   // Vertex coordinate along one axis of a cut edge, cube-local
   function automatic logic [PW-1:0] cut_coord(input logic [2:0] ca, input logic [2:0] cb,
                                               input int d, input logic [PW-1:0] t);
      logic [PW-1:0] base;
      logic [PW-1:0] tx;
      base = ca[d] ? ONE : '0;
      tx   = t;
      if (cb[d] && !ca[d]) return base + tx;
      else if (ca[d] && !cb[d]) return base - tx;
      else return base;
   endfunction

   // Grid coordinate with saturation at the top edge
   function automatic logic [CW-1:0] to_coord(input logic [GRID_BITS-1:0] o,
                                              input logic [PW-1:0] v);
      logic [CW:0] s;
      s = {1'b0, o, {FRAC_BITS{1'b0}}} + (CW+1)'(v);
      return s[CW] ? '1 : s[CW-1:0];
   endfunction

   // Fields of the current cube
   assign above = cube_ff[INS_LSB +: 8];
   assign mixed = cube_ff[MIX_LSB +: NUM_TETS];
   always_comb begin
      for (int d = 0; d < 3; d++) org[d] = cube_ff[ORG_LSB + d*GRID_BITS +: GRID_BITS];
      for (int c = 0; c < 4; c++) tmask[c] = above[TET_TAB[ti_ff][c]];
   end
   assign plan = tet_plan(tmask);

   // One corner value read per cycle
   assign ca_e   = TET_TAB[ti_ff][EDGE_A[e_ff]];
   assign cb_e   = TET_TAB[ti_ff][EDGE_B[e_ff]];
   assign cv_idx = (state_ff == S_EDGE_B) ? cb_e : ca_e;
   assign cv_sel = cube_ff[cv_idx*VALUE_W +: VALUE_W];
   assign ndiff  = $signed({{(VALUE_W + 1 - CORNER_W){iso[CORNER_W-1]}}, iso})
                 - $signed({va_ff[VALUE_W-1], va_ff});
   assign ddiff  = $signed({cv_sel[VALUE_W-1], cv_sel}) - $signed({va_ff[VALUE_W-1], va_ff});

   // Restoring divider step; the first step yields the integer bit (t = 1.0)
   assign r2 = (dcnt_ff == '0) ? rem_ff : {rem_ff[MAG_W-1:0], 1'b0};
   assign ge = (r2 >= {1'b0, den_ff});

   // Cut point for the vertex being loaded
   always_comb begin
      case (vcnt_ff)
         2'd0:    sidx = plan.src[0];
         2'd1:    sidx = tr_ff ? plan.src[2] : plan.src[1];
         default: sidx = tr_ff ? plan.src[3] : plan.src[2];
      endcase
   end
   assign ca_s = TET_TAB[ti_ff][EDGE_A[sidx]];
   assign cb_s = TET_TAB[ti_ff][EDGE_B[sidx]];

   // Shared multiplier operand select
   always_comb begin
      case (mstep_ff)
         4'd0:    begin ma = NRW'(e1_ff[1]); mb = CSW'(e2_ff[2]); end
         4'd1:    begin ma = NRW'(e1_ff[2]); mb = CSW'(e2_ff[1]); end
         4'd2:    begin ma = NRW'(e1_ff[2]); mb = CSW'(e2_ff[0]); end
         4'd3:    begin ma = NRW'(e1_ff[0]); mb = CSW'(e2_ff[2]); end
         4'd4:    begin ma = NRW'(e1_ff[0]); mb = CSW'(e2_ff[1]); end
         4'd5:    begin ma = NRW'(e1_ff[1]); mb = CSW'(e2_ff[0]); end
         4'd6:    begin ma = nr_ff[0]; mb = cs_ff[0]; end
         4'd7:    begin ma = nr_ff[1]; mb = cs_ff[1]; end
         default: begin ma = nr_ff[2]; mb = cs_ff[2]; end
      endcase
   end
   assign prod_in = PRW'(ma) * PRW'(mb);

   // Mixed tetrahedra after the current one
   always_comb begin
      later = 1'b0;
      for (int k = 0; k < NUM_TETS; k++)
         if ((3'(k) > ti_ff) && mixed[k]) later = 1'b1;
   end
   assign more      = plan.quad && !tr_ff;
   assign neg       = acc_ff[ACCW-1];
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign pop       = (state_ff == S_IDLE) && head_valid;

   always_comb begin
      for (int d = 0; d < 3; d++) begin
         vo[0][d] = to_coord(org[d], v_ff[0][d]);
         vo[1][d] = to_coord(org[d], neg ? v_ff[2][d] : v_ff[1][d]);
         vo[2][d] = to_coord(org[d], neg ? v_ff[1][d] : v_ff[2][d]);
      end
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      cube_in      = cube_ff;
      ti_in        = ti_ff;
      e_in         = e_ff;
      tr_in        = tr_ff;
      va_in        = va_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      q_in         = q_ff;
      dcnt_in      = dcnt_ff;
      t_in         = t_ff;
      vcnt_in      = vcnt_ff;
      v_in         = v_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      cs_in        = cs_ff;
      nr_in        = nr_ff;
      acc_in       = acc_ff;
      mstep_in     = mstep_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      s3    = '0;
      pn    = '0;
      sub3  = '0;
      sumd  = '0;
      s3cnt = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               cube_in  = head_data;
               ti_in    = '0;
               state_in = S_TET;
            end
         end
         S_TET: begin
            if (mixed[ti_ff]) begin
               e_in     = '0;
               state_in = S_EDGE_A;
            end else begin
               ti_in = ti_ff + 3'd1;
            end
         end
         S_EDGE_A: begin
            if (tmask[EDGE_A[e_ff]] != tmask[EDGE_B[e_ff]]) begin
               va_in    = cv_sel;
               state_in = S_EDGE_B;
            end else if (e_ff == 3'(NUM_EDGES - 1)) begin
               tr_in    = 1'b0;
               vcnt_in  = '0;
               state_in = S_VERT;
            end else begin
               e_in = e_ff + 3'd1;
            end
         end
         S_EDGE_B: begin
            rem_in   = {1'b0, ndiff[VALUE_W] ? MAG_W'(-ndiff) : MAG_W'(ndiff)};
            den_in   = ddiff[VALUE_W] ? MAG_W'(-ddiff) : MAG_W'(ddiff);
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = ge ? r2 - {1'b0, den_ff} : r2;
            q_in    = {q_ff[PW-2:0], ge};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCW'(FRAC_BITS)) begin
               t_in[e_ff] = {q_ff[PW-2:0], ge};
               if (e_ff == 3'(NUM_EDGES - 1)) begin
                  tr_in    = 1'b0;
                  vcnt_in  = '0;
                  state_in = S_VERT;
               end else begin
                  e_in     = e_ff + 3'd1;
                  state_in = S_EDGE_A;
               end
            end
         end
         S_VERT: begin
            for (int d = 0; d < 3; d++)
               v_in[vcnt_ff][d] = cut_coord(ca_s, cb_s, d, t_ff[sidx]);
            vcnt_in = vcnt_ff + 2'd1;
            if (vcnt_ff == 2'd2) state_in = S_PREP;
         end
         S_PREP: begin
            for (int d = 0; d < 3; d++) begin
               e1_in[d] = $signed({1'b0, v_ff[1][d]}) - $signed({1'b0, v_ff[0][d]});
               e2_in[d] = $signed({1'b0, v_ff[2][d]}) - $signed({1'b0, v_ff[0][d]});
               s3 = {2'b00, v_ff[0][d]} + {2'b00, v_ff[1][d]} + {2'b00, v_ff[2][d]};
               pn = (PW+3)'(s3) * (PW+3)'(plan.nin);
               sumd = '0;
               for (int c = 0; c < 4; c++)
                  if (tmask[c] && TET_TAB[ti_ff][c][d]) sumd = sumd + 2'd1;
               s3cnt = {2'b00, sumd} + {1'b0, sumd, 1'b0};
               sub3 = (PW+3)'(s3cnt) << FRAC_BITS;
               cs_in[d] = $signed({1'b0, pn}) - $signed({1'b0, sub3});
            end
            mstep_in = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            // Product of the previous step lands here
            case (mstep_ff) inside
               4'd1: nr_in[0] = NRW'(prod_ff);
               4'd2: nr_in[0] = nr_ff[0] - NRW'(prod_ff);
               4'd3: nr_in[1] = NRW'(prod_ff);
               4'd4: nr_in[1] = nr_ff[1] - NRW'(prod_ff);
               4'd5: nr_in[2] = NRW'(prod_ff);
               4'd6: nr_in[2] = nr_ff[2] - NRW'(prod_ff);
               4'd7: acc_in = ACCW'(prod_ff);
               4'd8, 4'd9: acc_in = acc_ff + ACCW'(prod_ff);
               default: acc_in = acc_ff;
            endcase
            mstep_in = mstep_ff + 4'd1;
            if (mstep_ff == 4'd9) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = !more && !later;
               rsp_data_in  = OUT_TW'({vo[2][2], vo[2][1], vo[2][0],
                                       vo[1][2], vo[1][1], vo[1][0],
                                       vo[0][2], vo[0][1], vo[0][0]});
               if (more) begin
                  tr_in    = 1'b1;
                  vcnt_in  = '0;
                  state_in = S_VERT;
               end else if (later) begin
                  ti_in    = ti_ff + 3'd1;
                  state_in = S_TET;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cube_ff     <= cube_in;
      ti_ff       <= ti_in;
      e_ff        <= e_in;
      tr_ff       <= tr_in;
      va_ff       <= va_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      q_ff        <= q_in;
      dcnt_ff     <= dcnt_in;
      t_ff        <= t_in;
      vcnt_ff     <= vcnt_in;
      v_ff        <= v_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      cs_ff       <= cs_in;
      nr_ff       <= nr_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      mstep_ff    <= mstep_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: hw/rtl/mtcm_checker.sv
// Port-level checks for the cube mesher, bound to the top level.
module mtcm_checker #(
   parameter int OUT_TW = 240
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [OUT_TW-1:0]                 rsp_tdata,
   input logic                              rsp_tlast,
   input logic                              psel,
   input logic                              penable,
   input logic                              pwrite,
   input logic [mtcm_pkg::CSR_ADDR_W-1:0]   paddr,
   input logic [mtcm_pkg::CSR_DATA_W-1:0]   pwdata,
   input logic [mtcm_pkg::CSR_DATA_W-1:0]   prdata
);
   // A stalled triangle holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // No triangle right out of reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

   // Written iso level reads back
   a_iso_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && !paddr[2] |=> paddr[2] || (prdata == $past(pwdata)))
      else $error("iso level read back mismatch");

endmodule

bind marching_tetrahedra_cube_mesher_unit mtcm_checker #(.OUT_TW(OUT_TW)) u_mtcm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata)
);
